/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk, disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define RGBBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define RGBBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rgbbm_pkg.sv */
// ----------------------------------------------------------------------------
// rgbbm_pkg
// Types and constants shared by the RGB breathing mode controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbbm_pkg;

  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned BTN_W   = 2;
  localparam int unsigned CFG_A_W = 8;

  localparam logic [BTN_W-1:0]   BTN_RELEASED = 2'd0;
  localparam logic [BTN_W-1:0]   BTN_PRESSED  = 2'd2;

  localparam logic [MODE_W-1:0]  MODE_OFF       = 4'd0;
  localparam logic [MODE_W-1:0]  MODE_AMBER_LO  = 4'd2;
  localparam logic [MODE_W-1:0]  MODE_AMBER_HI  = 4'd3;
  localparam logic [MODE_W-1:0]  MODE_BLUE_HI   = 4'd5;
  localparam logic [MODE_W-1:0]  MODE_GREEN_HI  = 4'd7;
  localparam logic [MODE_W-1:0]  MODE_LAST      = 4'd9;

  localparam logic [DUTY_W-1:0]  LEVEL_MAX      = 8'd255;
  localparam logic [DUTY_W-1:0]  FADE_TOP_RST   = 8'd255;
  localparam logic [DUTY_W-1:0]  AMBER_CAP_RST  = 8'd191;

  localparam logic [CFG_A_W-1:0] REG_FADE_TOP   = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_AMBER_CAP  = 8'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] level;
    logic              falling;
  } rgbbm_state_t;

  typedef struct packed {
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;
    logic [MODE_W-1:0] mode_now;
  } rgbbm_result_t;

  typedef struct packed {
    logic [BTN_W-1:0] button_status;
    logic             enable;
  } rgbbm_tick_t;

endpackage

/* sv/rgbbm_in_if.sv */
// ----------------------------------------------------------------------------
// rgbbm_in_if
// Tick channel: one word carries button status and enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgbbm_in_if
  import rgbbm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_status;
  logic             enable;

  modport source (output valid, output button_status, output enable, input ready);
  modport sink   (input valid, input button_status, input enable, output ready);
endinterface

/* sv/rgbbm_out_if.sv */
// ----------------------------------------------------------------------------
// rgbbm_out_if
// Result channel: one word carries the three duties and the mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgbbm_out_if
  import rgbbm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] red_duty;
  logic [DUTY_W-1:0] green_duty;
  logic [DUTY_W-1:0] blue_duty;
  logic [MODE_W-1:0] mode_now;

  modport source (output valid, output red_duty, output green_duty, output blue_duty,
                  output mode_now, input ready);
  modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                  input mode_now, output ready);
endinterface

/* sv/rgbbm_cfg_if.sv */
// ----------------------------------------------------------------------------
// rgbbm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rgbbm_cfg_if
  import rgbbm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] index;
  logic [DUTY_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/rgbbm_step.sv */
// ----------------------------------------------------------------------------
// rgbbm_step
// One tick of mode sequencing, duty selection and breathing ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbbm_step
  import rgbbm_pkg::*;
(
  input  rgbbm_state_t      state_cur,
  input  rgbbm_tick_t       tick,
  input  logic [DUTY_W-1:0] fade_top,
  input  logic [DUTY_W-1:0] amber_cap,
  output rgbbm_state_t      state_nxt,
  output rgbbm_result_t     result
);

  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] mode_nxt;
  logic [DUTY_W-1:0] lv;
  logic [DUTY_W-1:0] lv_nxt;
  logic [DUTY_W-1:0] amber_g;
  logic              turn;

  assign mode    = (state_cur.mode > MODE_LAST) ? MODE_OFF : state_cur.mode;
  assign lv      = state_cur.level;
  assign amber_g = (lv < amber_cap) ? lv : amber_cap;

  always_comb begin
    if (state_cur.falling) begin
      lv_nxt = (lv != '0) ? lv - 8'd1 : lv;
    end else begin
      lv_nxt = (lv != LEVEL_MAX) ? lv + 8'd1 : lv;
    end
  end

  assign turn = (lv_nxt == '0) || (lv_nxt >= fade_top);

  always_comb begin
    if (!mode[0]) begin
      mode_nxt = (tick.button_status == BTN_PRESSED) ? mode + 4'd1 : mode;
    end else if (tick.button_status == BTN_RELEASED) begin
      mode_nxt = (mode >= MODE_LAST) ? MODE_OFF : mode + 4'd1;
    end else begin
      mode_nxt = mode;
    end
  end

  always_comb begin
    state_nxt         = state_cur;
    result            = '0;
    if (!tick.enable) begin
      state_nxt.mode  = MODE_OFF;
    end else begin
      state_nxt.mode  = mode_nxt;
      if (mode >= MODE_AMBER_LO) begin
        state_nxt.level   = lv_nxt;
        state_nxt.falling = state_cur.falling ^ turn;
        if (mode <= MODE_AMBER_HI) begin
          result.red_duty   = lv;
          result.green_duty = amber_g;
        end else if (mode <= MODE_BLUE_HI) begin
          result.blue_duty  = lv;
        end else if (mode <= MODE_GREEN_HI) begin
          result.green_duty = lv;
        end else begin
          result.red_duty   = lv;
        end
      end
    end
    result.mode_now = state_nxt.mode;
  end

endmodule

/* sv/rgb_breathing_mode_controller.sv */
// ----------------------------------------------------------------------------
// rgb_breathing_mode_controller
// An accepted word waits in the tick register; the step logic then writes its
// result word into the output register. One word per cycle while out_ch is not
// stalled; the result word is registered in the same cycle as the state.
// Reset (rst_n low, synchronous): mode 0, level 0, ramp up, fade_top 255,
// amber_cap 191, both pipeline stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_breathing_mode_controller
  import rgbbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rgbbm_in_if.sink    in_ch,
  rgbbm_cfg_if.sink   cfg_ch,
  rgbbm_out_if.source out_ch
);

  `include "assert_macros.svh"

  logic              tick_vld_r;
  rgbbm_tick_t       tick_r;
  logic              out_vld_r;
  rgbbm_result_t     out_r;
  rgbbm_state_t      state_r;
  rgbbm_state_t      state_nxt;
  rgbbm_result_t     result_nxt;
  logic [DUTY_W-1:0] fade_top_r;
  logic [DUTY_W-1:0] amber_cap_r;
  logic              step_go;
  logic              in_fire;

  assign step_go   = tick_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !tick_vld_r || step_go;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  rgbbm_step u_step (
    .state_cur (state_r),
    .tick      (tick_r),
    .fade_top  (fade_top_r),
    .amber_cap (amber_cap_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // tick register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      tick_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_r.button_status <= in_ch.button_status;
      tick_r.enable        <= in_ch.enable;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (step_go) begin
        state_r <= state_nxt;
      end
      if (!out_vld_r || out_ch.ready) begin
        out_vld_r <= tick_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_r <= result_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_top_r  <= FADE_TOP_RST;
      amber_cap_r <= AMBER_CAP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FADE_TOP:  fade_top_r  <= cfg_ch.data;
        REG_AMBER_CAP: amber_cap_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.red_duty   = out_r.red_duty;
  assign out_ch.green_duty = out_r.green_duty;
  assign out_ch.blue_duty  = out_r.blue_duty;
  assign out_ch.mode_now   = out_r.mode_now;

  `RGBBM_ASSERT_NOW(a_mode_range, 1'b1, state_r.mode <= MODE_LAST, "mode out of range")
  `RGBBM_ASSERT_NEXT(a_tick_held, tick_vld_r && !step_go, tick_vld_r, "pending tick dropped")
  `RGBBM_ASSERT_NEXT(a_disable_off, step_go && !tick_r.enable,
    state_r.mode == MODE_OFF && out_r.red_duty == '0 && out_r.green_duty == '0 &&
    out_r.blue_duty == '0, "disable did not force off")
  `RGBBM_ASSERT_NEXT(a_level_step, step_go,
    state_r.level == $past(state_r.level) ||
    state_r.level == DUTY_W'($past(state_r.level) + 8'd1) ||
    state_r.level == DUTY_W'($past(state_r.level) - 8'd1), "level jumped")

endmodule

/* tb/rgb_breathing_mode_controller_checker.sv */
// ----------------------------------------------------------------------------
// rgb_breathing_mode_controller_checker
// Watches the tick, config and result channels of the breathing controller.
// Keeps its own copy of mode, level, ramp direction and both registers, works
// out the duty word for every accepted tick and compares each result word
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_breathing_mode_controller_checker
  import rgbbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [BTN_W-1:0]   in_button_status,
  input  logic               in_enable,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [DUTY_W-1:0]  cfg_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rgbbm_result_t      out_word,
  output int unsigned        n_pending,
  output int unsigned        n_checked,
  output int unsigned        n_failed
);

  logic [DUTY_W-1:0] fade_top_q;
  logic [DUTY_W-1:0] amber_cap_q;
  logic [MODE_W-1:0] mode_q;
  logic [DUTY_W-1:0] level_q;
  logic              falling_q;

  rgbbm_result_t duty_words_q[$];

  function automatic rgbbm_result_t step_lamp(input logic [BTN_W-1:0] btn, input logic en);
    rgbbm_result_t     res;
    logic [MODE_W-1:0] m;
    logic [DUTY_W-1:0] lv;
    res = '0;
    if (mode_q > MODE_LAST) mode_q = MODE_OFF;
    if (!en) begin
      mode_q = MODE_OFF;
    end else begin
      m  = mode_q;
      lv = level_q;
      if (m >= MODE_AMBER_LO) begin
        if (m <= MODE_AMBER_HI) begin
          res.red_duty   = lv;
          res.green_duty = (lv < amber_cap_q) ? lv : amber_cap_q;
        end else if (m <= MODE_BLUE_HI) begin
          res.blue_duty = lv;
        end else if (m <= MODE_GREEN_HI) begin
          res.green_duty = lv;
        end else begin
          res.red_duty = lv;
        end
        // breathing ramp, saturating at both ends
        if (falling_q) begin
          if (lv != '0) lv = lv - 1'b1;
        end else if (lv != LEVEL_MAX) begin
          lv = lv + 1'b1;
        end
        level_q = lv;
        if (lv == '0 || lv >= fade_top_q) falling_q = ~falling_q;
      end
      if (!m[0]) begin
        if (btn == BTN_PRESSED) m = m + 1'b1;
      end else if (btn == BTN_RELEASED) begin
        m = (m >= MODE_LAST) ? MODE_OFF : m + 1'b1;
      end
      mode_q = m;
    end
    res.mode_now = mode_q;
    return res;
  endfunction

  task automatic compare_field(input string fname, input logic [DUTY_W-1:0] want,
                               input logic [DUTY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
      n_failed++;
    end
  endtask

  always @(posedge clk) begin : watch
    rgbbm_result_t want;
    if (!rst_n) begin
      fade_top_q  = FADE_TOP_RST;
      amber_cap_q = AMBER_CAP_RST;
      mode_q      = MODE_OFF;
      level_q     = '0;
      falling_q   = 1'b0;
      duty_words_q.delete();
      n_checked   = 0;
      n_failed    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (duty_words_q.size() == 0) begin
          $error("result word with nothing outstanding: r=%0d g=%0d b=%0d mode=%0d",
                 out_word.red_duty, out_word.green_duty, out_word.blue_duty,
                 out_word.mode_now);
          n_failed++;
        end else begin
          want = duty_words_q.pop_front();
          compare_field("red_duty", want.red_duty, out_word.red_duty);
          compare_field("green_duty", want.green_duty, out_word.green_duty);
          compare_field("blue_duty", want.blue_duty, out_word.blue_duty);
          compare_field("mode_now", {4'd0, want.mode_now}, {4'd0, out_word.mode_now});
          n_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FADE_TOP) fade_top_q = cfg_data;
        else if (cfg_index == REG_AMBER_CAP) amber_cap_q = cfg_data;
      end
      if (in_valid && in_ready) duty_words_q.push_back(step_lamp(in_button_status, in_enable));
    end
    n_pending <= duty_words_q.size();
  end

endmodule

/* tb/rgb_breathing_mode_controller_tb.sv */
// ----------------------------------------------------------------------------
// rgb_breathing_mode_controller_tb
// Drives tick words into the breathing controller: a directed walk through
// every mode, button code and the enable override, then random button
// gestures (press, settle, release) with some noise, under six settings of
// fade_top and amber_cap and three idle patterns on the tick and result
// channels. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_breathing_mode_controller_tb;
  import rgbbm_pkg::*;

  localparam logic [BTN_W-1:0]   BTN_SETTLING = 2'd1;
  localparam logic [BTN_W-1:0]   BTN_UNUSED   = 2'd3;
  localparam logic [CFG_A_W-1:0] REG_UNMAPPED = 8'hFE;
  localparam int unsigned        STALL_LIMIT  = 2000;
  localparam int unsigned        DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned n_failed;

  rgbbm_in_if  in_ch();
  rgbbm_cfg_if cfg_ch();
  rgbbm_out_if out_ch();

  rgb_breathing_mode_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  rgb_breathing_mode_controller_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_button_status (in_ch.button_status),
    .in_enable        (in_ch.enable),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_word         ({out_ch.red_duty, out_ch.green_duty, out_ch.blue_duty,
                        out_ch.mode_now}),
    .n_pending        (n_pending),
    .n_checked        (n_checked),
    .n_failed         (n_failed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("rgb_breathing_mode_controller_tb failed");
        $finish;
      end
    end
  end

  // valid stays high across back-to-back words; only a gap lowers it
  task automatic send_tick(input logic [BTN_W-1:0] btn, input logic en);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.button_status <= btn;
    in_ch.enable        <= en;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [DUTY_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly press/settle/release gestures, some enable drops and odd codes
  task automatic run_gestures(input int unsigned n_words);
    int unsigned sent;
    int unsigned pick;
    int unsigned k;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_tick(BTN_W'($urandom_range(0, 3)), 1'b0);
        sent++;
      end else if (pick < 10) begin
        send_tick(BTN_UNUSED, 1'b1);
        sent++;
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) send_tick(BTN_PRESSED, 1'b1);
        sent += k;
        k = $urandom_range(0, 2);
        repeat (k) send_tick(BTN_SETTLING, 1'b1);
        sent += k;
        k = $urandom_range(1, 8);
        repeat (k) send_tick(BTN_RELEASED, 1'b1);
        sent += k;
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.button_status <= BTN_RELEASED;
    in_ch.enable        <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_FADE_TOP;
    cfg_ch.data         <= '0;
    src_idle_pct   = 30;
    sink_stall_pct = 71;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk: enable override, odd codes, every mode and the wrap
    send_tick(BTN_PRESSED, 1'b0);
    send_tick(BTN_UNUSED, 1'b1);
    send_tick(BTN_SETTLING, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);
    send_tick(BTN_UNUSED, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_SETTLING, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);
    send_tick(BTN_UNUSED, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_PRESSED, 1'b0);
    send_tick(BTN_RELEASED, 1'b1);
    send_tick(BTN_PRESSED, 1'b1);

    run_gestures(300);
    // a low top, which the level may already lie above
    write_reg(REG_FADE_TOP, 8'd5);
    write_reg(REG_AMBER_CAP, 8'd3);
    run_gestures(120);

    src_idle_pct   = 71;
    sink_stall_pct = 30;
    write_reg(REG_FADE_TOP, 8'd1);
    write_reg(REG_AMBER_CAP, 8'd0);
    run_gestures(120);
    write_reg(REG_FADE_TOP, 8'd0);
    write_reg(REG_AMBER_CAP, 8'd255);
    write_reg(REG_UNMAPPED, 8'h5A);
    run_gestures(120);

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_reg(REG_FADE_TOP, 8'd255);
    write_reg(REG_AMBER_CAP, 8'd128);
    run_gestures(350);
    write_reg(REG_FADE_TOP, 8'd40);
    write_reg(REG_AMBER_CAP, 8'd12);
    run_gestures(120);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d result words over six fade_top/amber_cap settings", n_checked);
    $display("idle mixes: sender 30/receiver 71, sender 71/receiver 30, none");
    if (n_failed == 0) begin
      $display("rgb_breathing_mode_controller_tb passed");
    end else begin
      $display("rgb_breathing_mode_controller_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/rgbbm_pkg.sv
sv/rgbbm_in_if.sv
sv/rgbbm_out_if.sv
sv/rgbbm_cfg_if.sv
sv/rgbbm_step.sv
sv/rgb_breathing_mode_controller.sv
tb/rgb_breathing_mode_controller_checker.sv
tb/rgb_breathing_mode_controller_tb.sv
